/* rtl/rcs_pkg.sv */
// Shared types and constants for the rectangle command setup block.
package rcs_pkg;

  // Command kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_RECT    = 2'd1,
    KIND_CAMERA  = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam int SCREEN_W     = 13;
  localparam int START_W      = 15;
  localparam int END_W        = 16;
  localparam int POS_W        = 24;
  localparam int REL_W        = POS_W + 1;
  localparam int SIZE_W       = 16;
  localparam int COLOR_W      = 32;
  localparam int START_MAX    = 32767;
  localparam int END_MIN      = -32768;

  localparam logic [SCREEN_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SCREEN_W-1:0] RESET_HEIGHT = 13'd480;

  // Pipeline advance controls shared by the datapath modules.
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } rcs_adv_t;

endpackage

/* rtl/rect_command_setup.sv */
// Top level of the rectangle command setup block: handshake, config and pipeline control.
//
// Input channel: one render command per transaction (in_valid / in_stall).
// Output channel: one span per clear or rectangle command (out_valid / out_stall).
// Set camera and unknown commands, and every command while halted, give no
// transaction on the output; they only update the camera or halt state.
// The pipeline has three register stages: input decode and camera subtract,
// the zoom multiplies, then truncation and clamping into the output register.
// A span reaches the output register through the input register and the multiply register,
// and one command is accepted every cycle while in_stall is low.
// empty_res is decoded from the output register.
// When the receiver stalls, the output register holds its span and the
// earlier stages keep filling; in_stall rises only once every stage is full.
// Reset empties the pipeline, restores the camera to offset 0 and zoom 1.0,
// clears the halt and loads the screen size 640 by 480.
// Screen size registers are written through wr_en / wr_index / wr_data; the user writes
// them only while no transaction is in flight, and the block itself does not enforce this.
module rect_command_setup #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [0:0]                           wr_index,
  input  logic [rcs_pkg::SCREEN_W-1:0]         wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           kind,
  input  logic                                 first_in_buffer,
  input  logic signed [rcs_pkg::POS_W-1:0]     pos_x,
  input  logic signed [rcs_pkg::POS_W-1:0]     pos_y,
  input  logic [rcs_pkg::SIZE_W-1:0]           size_w,
  input  logic [rcs_pkg::SIZE_W-1:0]           size_h,
  input  logic [15:0]                          zoom_value,
  input  logic [rcs_pkg::COLOR_W-1:0]          color,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rcs_pkg::START_W-1:0]          x_start,
  output logic [rcs_pkg::START_W-1:0]          y_start,
  output logic signed [rcs_pkg::END_W-1:0]     x_end,
  output logic signed [rcs_pkg::END_W-1:0]     y_end,
  output logic [rcs_pkg::COLOR_W-1:0]          fill_color,
  output logic                                 empty_res
);
  import rcs_pkg::*;

  localparam int ZW = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;

  logic v1, v2, v3;
  logic out_free, mv23, s2_free, mv12, s1_free, accept, produce;
  rcs_adv_t adv;

  logic signed [REL_W-1:0] rel_x, rel_y;
  logic [ZW-1:0]           zoom;
  logic [SIZE_W-1:0]       len_w, len_h;
  logic [DW-1:0]           dim_w, dim_h;
  logic                    is_clear;
  logic [COLOR_W-1:0]      fill1, fill2;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCREEN_WIDTH:  screen_width  <= wr_data;
        REG_SCREEN_HEIGHT: screen_height <= wr_data;
        default: ;
      endcase
    end
  end

  // Each stage moves forward when the stage after it is empty or moving.
  assign out_free = !v3 || !out_stall;
  assign mv23     = v2 && out_free;
  assign s2_free  = !v2 || mv23;
  assign mv12     = v1 && s2_free;
  assign s1_free  = !v1 || mv12;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  assign adv.load_mul = mv12;
  assign adv.load_out = mv23;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept && produce) begin
        v1 <= 1'b1;
      end else if (mv12) begin
        v1 <= 1'b0;
      end
      if (mv12) begin
        v2 <= 1'b1;
      end else if (mv23) begin
        v2 <= 1'b0;
      end
      if (mv23) begin
        v3 <= 1'b1;
      end else if (out_free) begin
        v3 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv12) begin
      fill2 <= fill1;
    end
    if (mv23) begin
      fill_color <= fill2;
    end
  end

  rcs_front #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .ZW        (ZW),
    .DW        (DW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .kind            (kind),
    .first_in_buffer (first_in_buffer),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .size_w          (size_w),
    .size_h          (size_h),
    .zoom_value      (zoom_value),
    .color           (color),
    .screen_width    (screen_width),
    .screen_height   (screen_height),
    .produce         (produce),
    .rel_x           (rel_x),
    .rel_y           (rel_y),
    .zoom            (zoom),
    .len_w           (len_w),
    .len_h           (len_h),
    .dim_w           (dim_w),
    .dim_h           (dim_h),
    .is_clear        (is_clear),
    .fill            (fill1)
  );

  rcs_axis #(
    .FRAC_BITS (FRAC_BITS),
    .ZW        (ZW),
    .DW        (DW)
  ) u_axis_x (
    .clk        (clk),
    .adv        (adv),
    .rel        (rel_x),
    .zoom       (zoom),
    .size       (len_w),
    .dim        (dim_w),
    .is_clear   (is_clear),
    .span_start (x_start),
    .span_end   (x_end)
  );

  rcs_axis #(
    .FRAC_BITS (FRAC_BITS),
    .ZW        (ZW),
    .DW        (DW)
  ) u_axis_y (
    .clk        (clk),
    .adv        (adv),
    .rel        (rel_y),
    .zoom       (zoom),
    .size       (len_h),
    .dim        (dim_h),
    .is_clear   (is_clear),
    .span_start (y_start),
    .span_end   (y_end)
  );

  assign out_valid = v3;
  assign empty_res = ($signed({1'b0, x_start}) >= x_end) ||
                     ($signed({1'b0, y_start}) >= y_end);

endmodule

/* rtl/rcs_front.sv */
// Command decode, camera state and the input register stage.
module rcs_front #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8,
  parameter int ZW        = 16,
  parameter int DW        = 13
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [1:0]                             kind,
  input  logic                                   first_in_buffer,
  input  logic signed [rcs_pkg::POS_W-1:0]       pos_x,
  input  logic signed [rcs_pkg::POS_W-1:0]       pos_y,
  input  logic [rcs_pkg::SIZE_W-1:0]             size_w,
  input  logic [rcs_pkg::SIZE_W-1:0]             size_h,
  input  logic [15:0]                            zoom_value,
  input  logic [rcs_pkg::COLOR_W-1:0]            color,
  input  logic [rcs_pkg::SCREEN_W-1:0]           screen_width,
  input  logic [rcs_pkg::SCREEN_W-1:0]           screen_height,
  output logic                                   produce,
  output logic signed [rcs_pkg::REL_W-1:0]       rel_x,
  output logic signed [rcs_pkg::REL_W-1:0]       rel_y,
  output logic [ZW-1:0]                          zoom,
  output logic [rcs_pkg::SIZE_W-1:0]             len_w,
  output logic [rcs_pkg::SIZE_W-1:0]             len_h,
  output logic [DW-1:0]                          dim_w,
  output logic [DW-1:0]                          dim_h,
  output logic                                   is_clear,
  output logic [rcs_pkg::COLOR_W-1:0]            fill
);
  import rcs_pkg::*;

  localparam int CMPW = (DW > SCREEN_W) ? DW : SCREEN_W;
  localparam logic [ZW-1:0] ZOOM_ONE = ZW'(1) << FRAC_BITS;

  logic signed [POS_W-1:0] camera_x;
  logic signed [POS_W-1:0] camera_y;
  logic [ZW-1:0]           camera_zoom;
  logic                    halted;

  logic signed [POS_W-1:0] cam_x_eff;
  logic signed [POS_W-1:0] cam_y_eff;
  logic [ZW-1:0]           zoom_eff;
  logic                    halted_eff;
  logic [CMPW-1:0]         sw_ext;
  logic [CMPW-1:0]         sh_ext;
  kind_t                   cmd;

  // A first-in-buffer mark restores the camera before the command is decoded.
  assign cam_x_eff  = first_in_buffer ? '0 : camera_x;
  assign cam_y_eff  = first_in_buffer ? '0 : camera_y;
  assign zoom_eff   = first_in_buffer ? ZOOM_ONE : camera_zoom;
  assign halted_eff = first_in_buffer ? 1'b0 : halted;
  assign cmd        = kind_t'(kind);

  assign produce = !halted_eff && ((cmd == KIND_CLEAR) || (cmd == KIND_RECT));

  assign sw_ext = CMPW'(screen_width);
  assign sh_ext = CMPW'(screen_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x    <= '0;
      camera_y    <= '0;
      camera_zoom <= ZOOM_ONE;
      halted      <= 1'b0;
    end else if (accept) begin
      camera_x    <= cam_x_eff;
      camera_y    <= cam_y_eff;
      camera_zoom <= zoom_eff;
      halted      <= halted_eff;
      if (!halted_eff) begin
        unique case (cmd)
          KIND_CAMERA: begin
            camera_x    <= pos_x;
            camera_y    <= pos_y;
            camera_zoom <= ZW'(zoom_value);
          end
          KIND_UNKNOWN: halted <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rel_x    <= REL_W'(pos_x) - REL_W'(cam_x_eff);
      rel_y    <= REL_W'(pos_y) - REL_W'(cam_y_eff);
      zoom     <= zoom_eff;
      len_w    <= size_w;
      len_h    <= size_h;
      dim_w    <= (sw_ext > CMPW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(screen_width);
      dim_h    <= (sh_ext > CMPW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(screen_height);
      is_clear <= (cmd == KIND_CLEAR);
      fill     <= color;
    end
  end

endmodule

/* rtl/rcs_axis.sv */
// One axis of the span datapath: scale stage, then truncate and clamp stage.
module rcs_axis #(
  parameter int FRAC_BITS = 8,
  parameter int ZW        = 16,
  parameter int DW        = 13
) (
  input  logic                                 clk,
  input  rcs_pkg::rcs_adv_t                    adv,
  input  logic signed [rcs_pkg::REL_W-1:0]     rel,
  input  logic [ZW-1:0]                        zoom,
  input  logic [rcs_pkg::SIZE_W-1:0]           size,
  input  logic [DW-1:0]                        dim,
  input  logic                                 is_clear,
  output logic [rcs_pkg::START_W-1:0]          span_start,
  output logic signed [rcs_pkg::END_W-1:0]     span_end
);
  import rcs_pkg::*;

  localparam int PW  = REL_W + ZW + 1;
  localparam int DTW = DW + 2 * FRAC_BITS - 1;
  localparam int SW  = ((PW > DTW + 1) ? PW : DTW + 1) + 1;
  localparam int LW  = SIZE_W + ZW + FRAC_BITS;
  localparam int EW  = ((SW > LW + 1) ? SW : LW + 1) + 1;
  localparam int FB2 = 2 * FRAC_BITS;
  localparam int QW  = EW - FB2;
  localparam logic signed [QW-1:0] Q_START_MAX = QW'(START_MAX);
  localparam logic signed [QW-1:0] Q_END_MIN   = QW'(END_MIN);

  // Division by the fixed-point scale, truncating toward zero.
  function automatic logic signed [QW-1:0] trunc_q(input logic signed [EW-1:0] v);
    logic signed [QW-1:0] q;
    q = v[EW-1:FB2];
    if (v[EW-1] && (|v[FB2-1:0])) begin
      q = q + QW'(1);
    end
    return q;
  endfunction

  logic signed [PW-1:0] prod;
  logic [SW-1:0]        dim_term;
  logic [LW-1:0]        len_next;
  logic signed [SW-1:0] s_pos;
  logic [LW-1:0]        s_len;
  logic [DW-1:0]        s_dim;
  logic                 s_clear;

  logic signed [EW-1:0] lo_full;
  logic signed [EW-1:0] hi_full;
  logic signed [QW-1:0] q_lo;
  logic signed [QW-1:0] q_hi;
  logic signed [QW-1:0] q_dim;

  assign prod     = rel * $signed({1'b0, zoom});
  assign dim_term = SW'(dim) << (FB2 - 1);
  assign len_next = (LW'(size) * LW'(zoom)) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv.load_mul) begin
      s_pos   <= SW'(prod) + $signed(dim_term);
      s_len   <= len_next;
      s_dim   <= dim;
      s_clear <= is_clear;
    end
  end

  assign lo_full = EW'(s_pos);
  assign hi_full = EW'(s_pos) + $signed(EW'(s_len));
  assign q_lo    = trunc_q(lo_full);
  assign q_hi    = trunc_q(hi_full);
  assign q_dim   = $signed(QW'(s_dim));

  always_ff @(posedge clk) begin
    if (adv.load_out) begin
      if (s_clear) begin
        span_start <= '0;
        span_end   <= END_W'(s_dim);
      end else begin
        if (q_lo < 0) begin
          span_start <= '0;
        end else if (q_lo > Q_START_MAX) begin
          span_start <= START_W'(START_MAX);
        end else begin
          span_start <= q_lo[START_W-1:0];
        end
        if (q_hi > q_dim) begin
          span_end <= END_W'(s_dim);
        end else if (q_hi < Q_END_MIN) begin
          span_end <= END_W'(END_MIN);
        end else begin
          span_end <= q_hi[END_W-1:0];
        end
      end
    end
  end

endmodule

/* bench/rcs_span_checker.sv */
// Checker for rect_command_setup: tracks camera and screen size, predicts spans, compares.
module rcs_span_checker #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [0:0]                          wr_index,
  input  logic [rcs_pkg::SCREEN_W-1:0]        wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic                                first_in_buffer,
  input  logic signed [rcs_pkg::POS_W-1:0]    pos_x,
  input  logic signed [rcs_pkg::POS_W-1:0]    pos_y,
  input  logic [rcs_pkg::SIZE_W-1:0]          size_w,
  input  logic [rcs_pkg::SIZE_W-1:0]          size_h,
  input  logic [15:0]                         zoom_value,
  input  logic [rcs_pkg::COLOR_W-1:0]         color,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [rcs_pkg::START_W-1:0]         x_start,
  input  logic [rcs_pkg::START_W-1:0]         y_start,
  input  logic signed [rcs_pkg::END_W-1:0]    x_end,
  input  logic signed [rcs_pkg::END_W-1:0]    y_end,
  input  logic [rcs_pkg::COLOR_W-1:0]         fill_color,
  input  logic                                empty_res,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  commands,
  output int                                  spans,
  output int                                  empties
);
  import rcs_pkg::*;

  typedef struct packed {
    logic [START_W-1:0] xs;
    logic [START_W-1:0] ys;
    logic [END_W-1:0]   xe;
    logic [END_W-1:0]   ye;
    logic [COLOR_W-1:0] col;
    logic               emp;
  } span_t;

  span_t            expected_spans[$];
  logic [SCREEN_W-1:0] width_reg;
  logic [SCREEN_W-1:0] height_reg;
  longint           cam_x;
  longint           cam_y;
  longint           zoom_reg;
  bit               halted;

  initial begin
    fail_count = 0;
    pending    = 0;
    commands   = 0;
    spans      = 0;
    empties    = 0;
  end

  task automatic check_field(input string name, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // One axis of a rectangle: screen = rel * zoom + dim / 2 at twice the fraction
  // bits, each end truncated toward zero, then clamped.
  function automatic void span_axis(input longint rel, input longint size,
                                    input longint dim, output longint lo,
                                    output longint hi);
    longint one2;
    longint s;
    longint len;
    one2 = longint'(1) << (2 * FRAC_BITS);
    s    = rel * zoom_reg + dim * (longint'(1) << (2 * FRAC_BITS - 1));
    len  = size * zoom_reg * (longint'(1) << FRAC_BITS);
    lo   = s / one2;
    hi   = (s + len) / one2;
    if (lo < 0) lo = 0;
    if (lo > START_MAX) lo = START_MAX;
    if (hi > dim) hi = dim;
    if (hi < END_MIN) hi = END_MIN;
  endfunction

  always @(posedge clk) begin : watch
    span_t  want;
    longint w;
    longint h;
    longint x0;
    longint x1;
    longint y0;
    longint y1;
    if (rst) begin
      expected_spans.delete();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      cam_x      = 0;
      cam_y      = 0;
      zoom_reg   = longint'(1) << FRAC_BITS;
      halted     = 1'b0;
      pending   <= 0;
    end else begin
      // Outputs first: a span leaving now never belongs to a command entering now.
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected span, expected none, got x %0d..%0d y %0d..%0d %h empty %b",
                   $time, x_start, x_end, y_start, y_end, fill_color, empty_res);
        end else begin
          want = expected_spans.pop_front();
          check_field("x_start", want.xs, x_start);
          check_field("y_start", want.ys, y_start);
          check_field("x_end", $signed(want.xe), x_end);
          check_field("y_end", $signed(want.ye), y_end);
          check_field("fill_color", want.col, fill_color);
          check_field("empty_res", want.emp, empty_res);
          spans++;
          if (want.emp) empties++;
        end
      end

      if (wr_en) begin
        case (wr_index)
          REG_SCREEN_WIDTH:  width_reg = wr_data;
          REG_SCREEN_HEIGHT: height_reg = wr_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        commands++;
        if (first_in_buffer) begin
          cam_x    = 0;
          cam_y    = 0;
          zoom_reg = longint'(1) << FRAC_BITS;
          halted   = 1'b0;
        end
        if (!halted) begin
          w = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
          h = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
          case (kind)
            KIND_CAMERA: begin
              cam_x    = pos_x;
              cam_y    = pos_y;
              zoom_reg = zoom_value;
            end
            KIND_UNKNOWN: halted = 1'b1;
            default: begin
              if (kind == KIND_CLEAR) begin
                x0 = 0;
                y0 = 0;
                x1 = w;
                y1 = h;
              end else begin
                span_axis(pos_x - cam_x, size_w, w, x0, x1);
                span_axis(pos_y - cam_y, size_h, h, y0, y1);
              end
              want.xs  = START_W'(x0);
              want.ys  = START_W'(y0);
              want.xe  = END_W'(x1);
              want.ye  = END_W'(y1);
              want.col = color;
              want.emp = (x0 >= x1) || (y0 >= y1);
              expected_spans.push_back(want);
            end
          endcase
        end
      end
      pending <= expected_spans.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the rect_command_setup testbench: clock, reset, stimulus phases and verdict.
module testbench;
  import rcs_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     wr_en = 1'b0;
  logic [0:0]               wr_index = '0;
  logic [SCREEN_W-1:0]      wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               kind = '0;
  logic                     first_in_buffer = 1'b0;
  logic signed [POS_W-1:0]  pos_x = '0;
  logic signed [POS_W-1:0]  pos_y = '0;
  logic [SIZE_W-1:0]        size_w = '0;
  logic [SIZE_W-1:0]        size_h = '0;
  logic [15:0]              zoom_value = '0;
  logic [COLOR_W-1:0]       color = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [START_W-1:0]       x_start;
  logic [START_W-1:0]       y_start;
  logic signed [END_W-1:0]  x_end;
  logic signed [END_W-1:0]  y_end;
  logic [COLOR_W-1:0]       fill_color;
  logic                     empty_res;

  int fail_count;
  int pending;
  int commands;
  int spans;
  int empties;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;

  rect_command_setup dut (.*);
  rcs_span_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("rect_command_setup verification failed");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when requested so the pipe backs up.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_cmd(input kind_t k, input logic f, input logic [POS_W-1:0] px,
                          input logic [POS_W-1:0] py, input logic [SIZE_W-1:0] sw,
                          input logic [SIZE_W-1:0] sh, input logic [15:0] zv,
                          input logic [COLOR_W-1:0] c);
    int gap;
    gap = 0;
    while (gap < 30 && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    kind            <= k;
    first_in_buffer <= f;
    pos_x           <= px;
    pos_y           <= py;
    size_w          <= sw;
    size_h          <= sh;
    zoom_value      <= zv;
    color           <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_screen(input int w, input int h);
    wr_en    <= 1'b1;
    wr_index <= REG_SCREEN_WIDTH;
    wr_data  <= SCREEN_W'(w);
    @(posedge clk);
    wr_index <= REG_SCREEN_HEIGHT;
    wr_data  <= SCREEN_W'(h);
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  // Wait for every span to come out, then for commands that give none to clear the pipe.
  // The first edge lets the count pick up the transaction accepted last.
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Positions are either anywhere in Q15.8 or within a few hundred pixels of the origin.
  function automatic logic [POS_W-1:0] rand_pos();
    int v;
    if ($urandom_range(2) == 0) return POS_W'($urandom);
    v = $urandom_range(0, 393216);
    return POS_W'(v - 196608);
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    if ($urandom_range(3) == 0) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(0, 400));
  endfunction

  function automatic int MAX_DIM_DEFAULT();
    return 4096;
  endfunction

  initial begin
    int    ph;
    int    n;
    int    r;
    kind_t k;
    logic  f;
    bit    halt_s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed commands at the reset screen size.
    send_cmd(KIND_CLEAR, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_cmd(KIND_RECT, 0, 24'h000A00, 24'hFFF600, 10, 20, 0, 32'h0000_0000);
    send_cmd(KIND_RECT, 0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 0, 32'h8040_2010);
    send_cmd(KIND_RECT, 0, 24'h800000, 24'h800000, 16'hFFFF, 16'hFFFF, 0, 32'h0102_0304);
    send_cmd(KIND_RECT, 0, 24'hFFFE80, 24'h000180, 0, 1, 0, 32'hA5A5_5A5A);
    send_cmd(KIND_RECT, 0, 24'hFFFE80, 24'hFFFF80, 1, 1, 0, 32'h5A5A_A5A5);
    send_cmd(KIND_CAMERA, 0, 24'h006480, 24'hFFEBC0, 0, 0, 16'h0200, 0);
    send_cmd(KIND_RECT, 0, 24'h006000, 24'hFFE000, 40, 30, 0, 32'h00FF_00FF);
    send_cmd(KIND_CAMERA, 0, 0, 0, 0, 0, 16'h0000, 0);
    send_cmd(KIND_RECT, 0, 24'h001000, 24'h001000, 100, 100, 0, 32'hFF00_FF00);
    send_cmd(KIND_CAMERA, 0, 24'h7FFFFF, 24'h800000, 0, 0, 16'hFFFF, 0);
    send_cmd(KIND_RECT, 0, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 0, 32'h1111_1111);
    // A new buffer restores the camera; this start lies past the right edge.
    send_cmd(KIND_RECT, 1, 24'h7FFFFF, 0, 1, 1, 0, 32'h2222_2222);
    send_cmd(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 32'h3333_3333);
    send_cmd(KIND_CAMERA, 0, 24'h010000, 0, 0, 0, 16'h0080, 0);
    send_cmd(KIND_RECT, 0, 0, 0, 5, 5, 0, 32'h4444_4444);
    send_cmd(KIND_RECT, 1, 0, 0, 50, 50, 0, 32'h5555_5555);
    send_cmd(KIND_UNKNOWN, 1, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_CAMERA, 1, 24'hFFF000, 24'h001000, 0, 0, 16'h0180, 0);
    send_cmd(KIND_RECT, 0, 0, 0, 16, 16, 0, 32'h6666_6666);
    send_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 32'h1234_5678);
    in_valid <= 1'b0;
    settle();

    halt_s = 1'b0;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_screen(640, 480);
        1: set_screen(1, 1);
        2: set_screen(MAX_DIM_DEFAULT(), MAX_DIM_DEFAULT());
        3: set_screen(8191, 0);
        4: set_screen(0, 8191);
        5: set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
        6: set_screen($urandom_range(0, 8191), $urandom_range(0, 8191));
        default: set_screen(320, 200);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph == 0) hold_req = 1'b1;

      n = 0;
      while (n < 100) begin
        r = $urandom_range(99);
        if (r < 15) k = KIND_CLEAR;
        else if (r < 70) k = KIND_RECT;
        else if (r < 96) k = KIND_CAMERA;
        else k = KIND_UNKNOWN;
        f = ($urandom_range(99) < 10);
        // Commands sent while halted are dropped by the block and are not counted.
        if (f) halt_s = 1'b0;
        if (!halt_s) begin
          n++;
          if (k == KIND_UNKNOWN) halt_s = 1'b1;
        end
        send_cmd(k, f, rand_pos(), rand_pos(), rand_size(), rand_size(),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024)),
                 $urandom);
      end
      in_valid <= 1'b0;
      settle();
    end

    $display("Summary: %0d commands sent, %0d spans checked, %0d of them empty.",
             commands, spans, empties);
    $display("Screens from 0 to 8191 pixels, with sender gaps, output stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("rect_command_setup verification clean");
    end else begin
      $display("rect_command_setup verification failed");
    end
    $finish;
  end

endmodule
